// ===== design/sem_pkg.sv =====
package sem_pkg;

  localparam int unsigned LINE_WIDTH_MAX = 1024;
  localparam int unsigned HEIGHT_LIMIT   = 4096;
  localparam int unsigned COL_W          = $clog2(LINE_WIDTH_MAX);
  localparam int unsigned ROW_W          = $clog2(HEIGHT_LIMIT);
  localparam int unsigned WIDTH_W        = 11;
  localparam int unsigned HEIGHT_W       = 13;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned PIX_W          = 3 * CHAN_W;
  // sum of two squares of |g| <= 1020 fits in 21 bits
  localparam int unsigned SUMSQ_W        = 21;
  localparam int unsigned ROOT_W         = 11;
  localparam int unsigned REM_W          = 12;
  localparam int unsigned CLAMP_MAX      = 255;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_SQ,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ===== design/sem_pix_if.sv =====
interface sem_pix_if;
  import sem_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] pixel_blue;
  logic [CHAN_W-1:0] pixel_green;
  logic [CHAN_W-1:0] pixel_red;
  modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink   (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

// ===== design/sem_res_if.sv =====
interface sem_res_if;
  import sem_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_red;
  logic              frame_done;
  modport source (output valid, out_row, out_col, out_blue, out_green, out_red, frame_done,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_blue, out_green, out_red, frame_done,
                  output ready);
endinterface

// ===== design/sem_cfg_if.sv =====
interface sem_cfg_if;
  import sem_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// ===== design/sobel_edge_magnitude_rgb.sv =====
// sobel edge magnitude over an rgb raster stream
// channels: pix_i takes one pixel per item in raster order, res_o gives
// result items (row, column, three channel values, frame_done), cfg_i
// writes image_width (index 0) and image_height (index 1) while idle
// each input item gives zero to three result items; the last row is
// interleaved with the row above, so results are not strictly raster order
// one item at a time; for each item the 11-step square-root recurrence
// runs between accept and the first result
// the two line stores share one 1024 x 48 memory, read at accept and
// written back in the next cycle
// a stalled receiver holds the output register; the block waits with
// the pending results and takes no new item until they are all sent
// reset: position (0,0), window zero, size 3 x 3, line memory left as is
module sobel_edge_magnitude_rgb (
  input  logic clk_i,
  input  logic rst_ni,
  sem_pix_if.sink   pix_i,
  sem_res_if.source res_o,
  sem_cfg_if.sink   cfg_i
);
  import sem_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [WIDTH_W-1:0]  width_m1;
  logic [HEIGHT_W-1:0] height_m1;

  // stream position
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;

  // current item
  pixel_t px_q;
  pixel_t mid_q;
  logic [ROW_W-1:0] er_q;
  logic [COL_W-1:0] ec_q;
  logic             interior_q;
  logic             last_col_q;
  logic [2:0]       pend_q, pend_d;

  // window and line memory: entry holds {older, recent}
  pixel_t win_q [9];
  logic [2*PIX_W-1:0] line_mem [LINE_WIDTH_MAX];
  logic [2*PIX_W-1:0] rd_q;
  pixel_t top_px, mid_px;
  logic last_col, last_row;

  // squares and roots
  logic [SUMSQ_W-1:0] sumsq [3];
  logic [2:0]         sq_done;
  logic [CHAN_W-1:0]  mag [3];
  logic               sq_start;

  // output register
  logic              out_valid_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  pixel_t            out_px_q;
  logic              out_done_q;
  logic              out_free;
  logic              load_out;

  logic in_acc, cfg_acc;

  assign in_acc  = pix_i.valid && pix_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  // register writes only with nothing in flight
  assign cfg_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(3);
      height_q <= HEIGHT_W'(3);
    end else if (cfg_acc) begin
      unique case (cfg_i.reg_idx)
        REG_WIDTH:  width_q  <= cfg_i.wdata[WIDTH_W-1:0];
        REG_HEIGHT: height_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // effective size minus one, zero counts as one, above the limit as the limit
  always_comb begin
    if (width_q == '0) begin
      width_m1 = '0;
    end else if (width_q > WIDTH_W'(LINE_WIDTH_MAX)) begin
      width_m1 = WIDTH_W'(LINE_WIDTH_MAX - 1);
    end else begin
      width_m1 = WIDTH_W'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      height_m1 = '0;
    end else if (height_q > HEIGHT_W'(HEIGHT_LIMIT)) begin
      height_m1 = HEIGHT_W'(HEIGHT_LIMIT - 1);
    end else begin
      height_m1 = HEIGHT_W'(height_q - 1'b1);
    end
  end

  assign last_col = {1'b0, col_q} >= width_m1;
  assign last_row = {1'b0, row_q} >= height_m1;
  assign top_px   = rd_q[2*PIX_W-1:PIX_W];
  assign mid_px   = rd_q[PIX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_WIN;
      ST_WIN:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_ROOT;
      ST_ROOT: if (sq_done[0]) state_d = ST_EMIT;
      ST_EMIT: if (pend_q == '0 || (out_free && $onehot(pend_q))) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pix_i.ready = 1'b0;
    sq_start    = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: pix_i.ready = 1'b1;
      ST_SQ:   sq_start    = 1'b1;
      ST_EMIT: load_out    = out_free && (pend_q != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // line memory, read at accept, written back in the next cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[col_q];
    end
    if (state_q == ST_WIN) begin
      line_mem[col_q] <= {mid_px, px_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= {pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue};
    end
    if (state_q == ST_WIN) begin
      mid_q      <= mid_px;
      er_q       <= row_q;
      ec_q       <= col_q;
      interior_q <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      last_col_q <= last_col;
    end
  end

  // window, position and pending results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      row_q  <= '0;
      col_q  <= '0;
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (state_q == ST_WIN) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i*3]   <= win_q[i*3+1];
          win_q[i*3+1] <= win_q[i*3+2];
        end
        win_q[2] <= top_px;
        win_q[5] <= mid_px;
        win_q[8] <= px_q;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : ROW_W'(row_q + 1'b1);
        end else begin
          col_q <= COL_W'(col_q + 1'b1);
        end
      end
    end
  end

  // pending results in order: up-left, up on last column, own on last row
  always_comb begin
    pend_d = pend_q;
    if (state_q == ST_WIN) begin
      pend_d[0] = (row_q != '0) && (col_q != '0);
      pend_d[1] = (row_q != '0) && last_col;
      pend_d[2] = last_row;
    end else if (load_out) begin
      if (pend_q[0]) begin
        pend_d[0] = 1'b0;
      end else if (pend_q[1]) begin
        pend_d[1] = 1'b0;
      end else begin
        pend_d[2] = 1'b0;
      end
    end
  end

  // sobel gradients, squared, taken by the root units as they start
  function automatic logic [SUMSQ_W-1:0] grad_sumsq(input pixel_t w [9], input int sh);
    logic [9:0]  px_sum, nx_sum, py_sum, ny_sum;
    logic [10:0] gx, gy;
    logic [9:0]  ax, ay;
    px_sum = 10'(w[2][sh+:8]) + {w[5][sh+:8], 1'b0} + 10'(w[8][sh+:8]);
    nx_sum = 10'(w[0][sh+:8]) + {w[3][sh+:8], 1'b0} + 10'(w[6][sh+:8]);
    py_sum = 10'(w[6][sh+:8]) + {w[7][sh+:8], 1'b0} + 10'(w[8][sh+:8]);
    ny_sum = 10'(w[0][sh+:8]) + {w[1][sh+:8], 1'b0} + 10'(w[2][sh+:8]);
    gx = {1'b0, px_sum} - {1'b0, nx_sum};
    gy = {1'b0, py_sum} - {1'b0, ny_sum};
    ax = gx[10] ? 10'(-gx) : gx[9:0];
    ay = gy[10] ? 10'(-gy) : gy[9:0];
    return SUMSQ_W'(ax * ax) + SUMSQ_W'(ay * ay);
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sumsq[ch] = grad_sumsq(win_q, ch * CHAN_W);
    end
  end

  // one root unit per channel, the three run in lockstep
  for (genvar g = 0; g < 3; g++) begin : g_root
    sem_isqrt u_isqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (sq_start),
      .sumsq_i (sumsq[g]),
      .done_o  (sq_done[g]),
      .mag_o   (mag[g])
    );
  end

  // output register
  assign out_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (pend_q[0]) begin
        out_row_q  <= ROW_W'(er_q - 1'b1);
        out_col_q  <= COL_W'(ec_q - 1'b1);
        out_px_q   <= interior_q ? {mag[2], mag[1], mag[0]} : win_q[4];
        out_done_q <= 1'b0;
      end else if (pend_q[1]) begin
        out_row_q  <= ROW_W'(er_q - 1'b1);
        out_col_q  <= ec_q;
        out_px_q   <= mid_q;
        out_done_q <= 1'b0;
      end else begin
        out_row_q  <= er_q;
        out_col_q  <= ec_q;
        out_px_q   <= px_q;
        out_done_q <= last_col_q;
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_row    = out_row_q;
  assign res_o.out_col    = out_col_q;
  assign res_o.out_blue   = out_px_q[CHAN_W-1:0];
  assign res_o.out_green  = out_px_q[2*CHAN_W-1:CHAN_W];
  assign res_o.out_red    = out_px_q[PIX_W-1:2*CHAN_W];
  assign res_o.frame_done = out_done_q;

  // checks
  a_accept_to_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_WIN)
    else $error("accepted item did not move to window update");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pend_q == '0)
    else $error("results pending while idle");

  a_roots_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_done[0] == sq_done[1]) && (sq_done[1] == sq_done[2]))
    else $error("root units out of step");

endmodule

// ===== design/sem_isqrt.sv =====
module sem_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sem_pkg::SUMSQ_W-1:0]  sumsq_i,
  output logic                         done_o,
  output logic [sem_pkg::CHAN_W-1:0]   mag_o
);
  import sem_pkg::*;

  localparam int unsigned SH_W  = 2 * ROOT_W;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [SH_W-1:0]   sh_q, sh_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [REM_W+1:0]  part;
  logic [REM_W+1:0]  trial;
  logic [ROOT_W:0]   rounded;

  // one result bit a cycle, restoring digit recurrence
  always_comb begin
    part    = {rem_q, sh_q[SH_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    sh_d    = sh_q;
    root_d  = root_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (start_i) begin
      sh_d   = {{(SH_W-SUMSQ_W){1'b0}}, sumsq_i};
      root_d = '0;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      sh_d = {sh_q[SH_W-3:0], 2'b00};
      if (part >= trial) begin
        rem_d  = REM_W'(part - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(part);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = CNT_W'(cnt_q + 1'b1);
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  // round up when remainder exceeds root, then clamp
  always_comb begin
    rounded = {1'b0, root_q} + (ROOT_W+1)'(rem_q > REM_W'(root_q));
    if (rounded > (ROOT_W+1)'(CLAMP_MAX)) begin
      mag_o = CHAN_W'(CLAMP_MAX);
    end else begin
      mag_o = rounded[CHAN_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule
